// File: design/sic_instruction_execute_macros.svh
// Assertion macros used by the checker file
`ifndef SIC_INSTRUCTION_EXECUTE_MACROS_SVH
`define SIC_INSTRUCTION_EXECUTE_MACROS_SVH

// implication checked every edge outside reset
`define SIE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SIE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sie_pkg.sv
`default_nettype none
package sie_pkg;
	localparam int WORD_W = 24;
	localparam int PC_W = 15;

	typedef enum logic [4:0] {
		OP_LDA = 5'd0, OP_LDL = 5'd1, OP_LDX = 5'd2, OP_STA = 5'd3, OP_STL = 5'd4,
		OP_STX = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7, OP_MUL = 5'd8, OP_DIV = 5'd9,
		OP_LDCH = 5'd10, OP_STCH = 5'd11, OP_COMP = 5'd12, OP_TIX = 5'd13,
		OP_JEQ = 5'd14, OP_JGT = 5'd15, OP_JLT = 5'd16, OP_J = 5'd17,
		OP_JSUB = 5'd18, OP_RSUB = 5'd19, OP_RD = 5'd20, OP_WD = 5'd21,
		OP_TD = 5'd22, OP_HOST = 5'd23
	} op_t;

	localparam logic [1:0] CC_EQ = 2'd0;
	localparam logic [1:0] CC_LT = 2'd1;
	localparam logic [1:0] CC_GT = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_WR1, ST_WR2,
		ST_DIV, ST_EXEC, ST_OUT
	} state_t;

	// divider control
	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage
`default_nettype wire

// File: design/sie_divider.sv
`default_nettype none
module sie_divider import sie_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] dividend,
	input  wire logic [WORD_W-1:0] divisor,
	output div_ctl_t               ctl,
	output logic      [WORD_W-1:0] quotient
);
	// restoring divide, one bit a cycle
	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic [WORD_W:0]   trial;

	assign trial = {rem_q, quo_q[WORD_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'(WORD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// File: design/sie_memory.sv
`default_nettype none
module sie_memory import sie_pkg::*; #(
	parameter int MEM_BYTES = 32768
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(MEM_BYTES)-1:0] waddr,
	input  wire logic [7:0]                   wdata,
	input  wire logic [$clog2(MEM_BYTES)-1:0] raddr,
	output logic      [7:0]                   rdata
);
	logic [7:0] mem [MEM_BYTES];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/sic_instruction_execute.sv
`default_nettype none
// Channel     | Dir | Contents
// s_axis      | in  | tdata: op[4:0], addr[19:5], data_byte[27:20]
// m_axis      | out | tdata: acc, index_reg, link_reg, next_pc, cond_code,
//             |     |        char_valid, char_out, div_zero (low bit up)
// cfg         | in  | start_address, written when cfg_we is high
// After reset the memory is swept to zero, one byte a cycle, with s_axis_tready
// low. One instruction at a time: a word store or a word operand read makes
// three byte accesses on the single memory port, and DIV with a nonzero
// divisor also runs the bit-serial divider. The result sits in its own
// register: a stalled m_axis holds back only the next result, s_axis still
// takes the next beat.
module sic_instruction_execute import sie_pkg::*; #(
	parameter int MEM_BYTES = 32768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // op, addr, data_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [103:0]     m_axis_tdata,  // acc, index_reg, link_reg, next_pc,
	                                        // cond_code, char_valid, char_out, div_zero
	input  wire logic        cfg_we,
	input  wire logic [14:0] cfg_wdata     // start_address
);
	localparam int AW = $clog2(MEM_BYTES);

	state_t state_q, state_nx;
	logic [4:0]        op_q;
	logic [AW-1:0]     addr_q, maddr_q, raddr, waddr;
	logic [7:0]        db_q, rdata, wdata;
	logic              we;
	logic [WORD_W-1:0] a_q, x_q, l_q, opnd_q, wword_q, x_inc;
	logic [WORD_W-1:0] rd_word;
	logic [PC_W-1:0]   pc_q;
	logic [1:0]        cc_q;
	logic              cv_q, dz_q;
	logic [7:0]        ch_q;
	logic [AW:0]       clr_q;
	logic              div_start;
	div_ctl_t          div_ctl;
	logic [WORD_W-1:0] quotient;
	logic [2*WORD_W-1:0] prod;
	logic              is_word_rd, is_word_wr;
	logic [AW-1:0]     seq, tgt;
	logic              out_load;
	logic [98:0]       out_q;

	// operand word with its low byte straight off the memory port
	assign rd_word = {opnd_q[WORD_W-1:8], rdata};

	sie_memory #(.MEM_BYTES(MEM_BYTES)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);
	sie_divider u_div (
		.clk, .arst_n, .start(div_start), .dividend(a_q), .divisor(rd_word),
		.ctl(div_ctl), .quotient
	);

	always_comb begin
		is_word_rd = 1'b0;
		is_word_wr = 1'b0;
		unique case (op_q)
			OP_LDA, OP_LDL, OP_LDX, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_COMP,
			OP_TIX: is_word_rd = 1'b1;
			OP_STA, OP_STL, OP_STX: is_word_wr = 1'b1;
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	// result register free or being emptied this cycle
	assign out_load = (state_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
	assign x_inc = x_q + 24'd1;
	assign seq = AW'({1'b0, pc_q} + 16'd3);
	assign tgt = addr_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == (AW+1)'(MEM_BYTES - 1)) state_nx = ST_IDLE;
			ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_nx = ST_RD0;
			ST_RD0:   state_nx = is_word_rd ? ST_RD1 : (is_word_wr ? ST_WR1 : ST_EXEC);
			ST_RD1:   state_nx = ST_RD2;
			ST_RD2:   state_nx = ST_RD3;
			ST_RD3:   state_nx = (op_q == OP_DIV && rd_word != '0) ? ST_DIV : ST_EXEC;
			ST_WR1:   state_nx = ST_WR2;
			ST_WR2:   state_nx = ST_EXEC;
			ST_DIV:   if (!div_ctl.busy && !div_ctl.start) state_nx = ST_EXEC;
			ST_EXEC:  state_nx = ST_OUT;
			ST_OUT:   if (out_load) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = maddr_q;
		wdata = '0;
		raddr = maddr_q;
		div_start = (state_q == ST_RD3) && (op_q == OP_DIV) && (state_nx == ST_DIV);
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q[AW-1:0];
			end
			ST_RD0: begin
				if (is_word_wr) begin
					we = 1'b1;
					wdata = wword_q[23:16];
				end else if (op_q == OP_STCH) begin
					we = 1'b1;
					wdata = a_q[7:0];
				end else if (op_q == OP_HOST) begin
					we = 1'b1;
					wdata = db_q;
				end
			end
			ST_WR1: begin
				we = 1'b1;
				wdata = wword_q[15:8];
			end
			ST_WR2: begin
				we = 1'b1;
				wdata = wword_q[7:0];
			end
			default: ;
		endcase
	end

	assign prod = a_q * opnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			m_axis_tvalid <= 1'b0;
			a_q <= '0;
			x_q <= '0;
			l_q <= '0;
			pc_q <= '0;
			cc_q <= CC_EQ;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			m_axis_tvalid <= out_load || (m_axis_tvalid && !m_axis_tready);
			if (cfg_we) pc_q <= PC_W'(cfg_wdata[AW-1:0]);
			if (state_q == ST_EXEC) begin
				unique case (op_q)
					OP_LDA: a_q <= opnd_q;
					OP_LDL: l_q <= opnd_q;
					OP_LDX: x_q <= opnd_q;
					OP_ADD: a_q <= a_q + opnd_q;
					OP_SUB: a_q <= a_q - opnd_q;
					OP_MUL: a_q <= prod[WORD_W-1:0];
					OP_DIV: if (opnd_q != '0) a_q <= quotient;
					OP_LDCH: a_q <= {a_q[23:8], rdata};
					OP_RD: a_q <= {a_q[23:8], db_q};
					OP_COMP: cc_q <= (a_q == opnd_q) ? CC_EQ :
						((a_q < opnd_q) ? CC_LT : CC_GT);
					OP_TIX: begin
						x_q <= x_inc;
						cc_q <= (x_inc == opnd_q) ? CC_EQ :
							((x_inc < opnd_q) ? CC_LT : CC_GT);
					end
					OP_JSUB: l_q <= WORD_W'(seq);
					default: ;
				endcase
				unique case (op_q)
					OP_JEQ: pc_q <= PC_W'((cc_q == CC_EQ) ? tgt : seq);
					OP_JGT: pc_q <= PC_W'((cc_q == CC_GT) ? tgt : seq);
					OP_JLT: pc_q <= PC_W'((cc_q == CC_LT) ? tgt : seq);
					OP_J, OP_JSUB: pc_q <= PC_W'(tgt);
					OP_RSUB: pc_q <= PC_W'(l_q[AW-1:0]);
					OP_HOST: ;
					default: if (op_q < OP_HOST) pc_q <= PC_W'(seq);
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q <= s_axis_tdata[4:0];
			addr_q <= s_axis_tdata[5 +: AW];
			maddr_q <= s_axis_tdata[5 +: AW];
			db_q <= s_axis_tdata[27:20];
			cv_q <= 1'b0;
			ch_q <= '0;
			dz_q <= 1'b0;
			unique case (s_axis_tdata[4:0])
				OP_STL: wword_q <= l_q;
				OP_STX: wword_q <= x_q;
				default: wword_q <= a_q;
			endcase
		end
		if ((state_q == ST_RD0 && (is_word_rd || is_word_wr)) || state_q == ST_RD1
				|| state_q == ST_WR1)
			maddr_q <= maddr_q + 1'b1;
		if (state_q == ST_RD1) opnd_q[23:16] <= rdata;
		if (state_q == ST_RD2) opnd_q[15:8] <= rdata;
		if (state_q == ST_RD3) opnd_q[7:0] <= rdata;
		if (state_q == ST_EXEC) begin
			if (op_q == OP_WD) begin
				cv_q <= 1'b1;
				ch_q <= a_q[7:0];
			end
			if (op_q == OP_DIV && opnd_q == '0) dz_q <= 1'b1;
		end
		if (out_load) out_q <= {dz_q, ch_q, cv_q, cc_q, pc_q, l_q, x_q, a_q};
	end

	assign m_axis_tdata = {5'd0, out_q};
endmodule
`default_nettype wire

// File: design/sie_checker.sv
`default_nettype none
`include "sic_instruction_execute_macros.svh"
module sie_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [103:0] m_axis_tdata
);
	`SIE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
	`SIE_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
	`SIE_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[103:99] == 5'd0, "result padding not zero")
	`SIE_ASSERT_IMP(a_cc_range, m_axis_tvalid, m_axis_tdata[88:87] != 2'd3, "bad condition code")
endmodule

bind sic_instruction_execute sie_checker u_sie_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// File: verif/sic_instruction_execute_test.sv
module sic_instruction_execute_test;
	import sie_pkg::*;

	localparam int MEM_BYTES = 32768;

	// one result beat, fields in the order they sit in m_axis_tdata
	typedef struct packed {
		logic [4:0]  pad;
		logic        div_zero;
		logic [7:0]  char_out;
		logic        char_valid;
		logic [1:0]  cond_code;
		logic [14:0] next_pc;
		logic [23:0] link_reg;
		logic [23:0] index_reg;
		logic [23:0] acc;
	} sic_result_t;

	// machine state mirror and the queue of expected result beats
	class sic_scoreboard;
		logic [7:0]  mem [MEM_BYTES];
		logic [23:0] reg_a, reg_x, reg_l;
		logic [14:0] pc, start_addr;
		logic [1:0]  cc;
		sic_result_t pending [$];
		int          errors;

		function void clear_machine();
			foreach (mem[i]) mem[i] = 8'h00;
			reg_a = '0;
			reg_x = '0;
			reg_l = '0;
			cc = CC_EQ;
			start_addr = '0;
			pc = '0;
			errors = 0;
			pending.delete();
		endfunction

		function void set_start(logic [14:0] v);
			start_addr = v;
			pc = v;
		endfunction

		function logic [23:0] fetch_word(logic [14:0] a);
			return {mem[a], mem[15'(a + 1)], mem[15'(a + 2)]};
		endfunction

		function void store_word(logic [14:0] a, logic [23:0] w);
			mem[a] = w[23:16];
			mem[15'(a + 1)] = w[15:8];
			mem[15'(a + 2)] = w[7:0];
		endfunction

		function logic [1:0] order_of(logic [23:0] l, logic [23:0] r);
			if (l == r) return CC_EQ;
			else if (l < r) return CC_LT;
			return CC_GT;
		endfunction

		// execute one accepted instruction beat
		function void note_instruction(logic [4:0] op, logic [14:0] a, logic [7:0] db);
			logic [14:0] seq, npc;
			logic [23:0] w;
			sic_result_t r;
			seq = pc + 15'd3;
			npc = seq;
			r = '0;
			case (op)
				OP_LDA: reg_a = fetch_word(a);
				OP_LDL: reg_l = fetch_word(a);
				OP_LDX: reg_x = fetch_word(a);
				OP_STA: store_word(a, reg_a);
				OP_STL: store_word(a, reg_l);
				OP_STX: store_word(a, reg_x);
				OP_ADD: reg_a = reg_a + fetch_word(a);
				OP_SUB: reg_a = reg_a - fetch_word(a);
				OP_MUL: reg_a = 24'(reg_a * fetch_word(a));
				OP_DIV: begin
					w = fetch_word(a);
					if (w == 0) r.div_zero = 1'b1;
					else reg_a = reg_a / w;
				end
				OP_LDCH: reg_a[7:0] = mem[a];
				OP_STCH: mem[a] = reg_a[7:0];
				OP_COMP: cc = order_of(reg_a, fetch_word(a));
				OP_TIX: begin
					reg_x = reg_x + 24'd1;
					cc = order_of(reg_x, fetch_word(a));
				end
				OP_JEQ: if (cc == CC_EQ) npc = a;
				OP_JGT: if (cc == CC_GT) npc = a;
				OP_JLT: if (cc == CC_LT) npc = a;
				OP_J: npc = a;
				OP_JSUB: begin
					reg_l = 24'(seq);
					npc = a;
				end
				OP_RSUB: npc = reg_l[14:0];
				OP_RD: reg_a[7:0] = db;
				OP_WD: begin
					r.char_valid = 1'b1;
					r.char_out = reg_a[7:0];
				end
				OP_TD: ;
				OP_HOST: begin
					mem[a] = db;
					npc = pc;
				end
				default: npc = pc;
			endcase
			pc = npc;
			r.acc = reg_a;
			r.index_reg = reg_x;
			r.link_reg = reg_l;
			r.next_pc = pc;
			r.cond_code = cc;
			pending.push_back(r);
		endfunction

		function void check_result(sic_result_t got);
			sic_result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.acc !== exp.acc) report("acc", exp.acc, got.acc);
			if (got.index_reg !== exp.index_reg) report("index_reg", exp.index_reg, got.index_reg);
			if (got.link_reg !== exp.link_reg) report("link_reg", exp.link_reg, got.link_reg);
			if (got.next_pc !== exp.next_pc) report("next_pc", exp.next_pc, got.next_pc);
			if (got.cond_code !== exp.cond_code) report("cond_code", exp.cond_code, got.cond_code);
			if (got.char_valid !== exp.char_valid)
				report("char_valid", exp.char_valid, got.char_valid);
			if (got.char_out !== exp.char_out) report("char_out", exp.char_out, got.char_out);
			if (got.div_zero !== exp.div_zero) report("div_zero", exp.div_zero, got.div_zero);
		endfunction

		function void report(string f, logic [23:0] e, logic [23:0] g);
			$display("%0t: %s mismatch, expected %h, got %h", $time, f, e, g);
			errors++;
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata;  // op, addr, data_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;  // acc, index_reg, link_reg, next_pc, cond_code,
	                             // char_valid, char_out, div_zero
	logic         cfg_we;
	logic [14:0]  cfg_wdata;     // start_address

	sic_scoreboard machine;
	int send_idle_pct, recv_stall_pct;

	sic_instruction_execute #(.MEM_BYTES(MEM_BYTES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall, check every accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				machine.check_result(sic_result_t'(m_axis_tdata));
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one instruction beat, held until accepted, with optional idle cycles before it;
	// tvalid stays up after the beat until the next call or drain lowers it
	task automatic send_instr(op_t op, logic [14:0] a, logic [7:0] db);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, db, a, op};
		do @(posedge clk); while (!s_axis_tready);
		machine.note_instruction(op, a, db);
	endtask

	// every item yields a result, so an empty queue means the block is idle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (machine.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start(logic [14:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		machine.set_start(v);
	endtask

	// random address: mostly a small working area so loads see stored data,
	// sometimes the wrap region or anywhere
	function automatic logic [14:0] pick_addr();
		case ($urandom_range(9))
			0: return 15'(32768 - $urandom_range(3));
			1: return 15'($urandom);
			default: return 15'($urandom_range(63));
		endcase
	endfunction

	task automatic random_phase(int n);
		op_t op;
		for (int i = 0; i < n; i++) begin
			op = op_t'($urandom_range(OP_HOST));
			send_instr(op, pick_addr(), 8'($urandom));
		end
	endtask

	initial begin
		machine = new();
		machine.clear_machine();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		write_start(15'h7FFF);

		// directed: extreme words, wrap at memory end, every op kind
		send_instr(OP_HOST, 15'h7FFF, 8'hFF);
		send_instr(OP_HOST, 15'h0000, 8'hFF);
		send_instr(OP_HOST, 15'h0001, 8'hFF);
		send_instr(OP_LDA, 15'h7FFF, 8'h00);    // word straddles the end
		send_instr(OP_LDX, 15'h7FFF, 8'h00);
		send_instr(OP_ADD, 15'h7FFF, 8'h00);    // sum wraps at 24 bits
		send_instr(OP_MUL, 15'h7FFF, 8'h00);
		send_instr(OP_SUB, 15'h0100, 8'h00);
		send_instr(OP_DIV, 15'h0200, 8'h00);    // zero divisor
		send_instr(OP_DIV, 15'h7FFF, 8'h00);
		send_instr(OP_RD, 15'h0000, 8'hA5);     // low byte only
		send_instr(OP_STA, 15'h0010, 8'h00);
		send_instr(OP_STCH, 15'h0020, 8'h00);
		send_instr(OP_LDCH, 15'h0020, 8'h00);
		send_instr(OP_WD, 15'h0000, 8'h00);
		send_instr(OP_TD, 15'h0000, 8'h00);
		send_instr(OP_COMP, 15'h0010, 8'h00);
		send_instr(OP_JEQ, 15'h1234, 8'h00);
		send_instr(OP_TIX, 15'h7FFF, 8'h00);
		send_instr(OP_JLT, 15'h0040, 8'h00);
		send_instr(OP_JGT, 15'h0050, 8'h00);
		send_instr(OP_JSUB, 15'h7FFE, 8'h00);
		send_instr(OP_STL, 15'h0030, 8'h00);
		send_instr(OP_STX, 15'h0033, 8'h00);
		send_instr(OP_RSUB, 15'h0000, 8'h00);
		send_instr(OP_J, 15'h7FFF, 8'h00);
		send_instr(OP_LDL, 15'h0030, 8'h00);

		write_start(15'h0000);
		random_phase(110);
		send_idle_pct = 47;
		random_phase(110);
		// hold off until everything is back, then carry on
		drain();
		write_start(15'h2AAA);
		send_idle_pct = 0;
		recv_stall_pct = 47;
		random_phase(110);
		write_start(15'h5555);
		send_idle_pct = 18;
		recv_stall_pct = 18;
		random_phase(110);

		fork
			begin
				drain();
				repeat (40) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
				machine.errors++;
				$display("%0t: results still outstanding at the end", $time);
			end
		join_any
		if (machine.errors == 0 && machine.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// the clearing sweep and the rest of the run stay far below this bound
	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
